// ===== hw/rtl/kmms_pkg.sv =====
package kmms_pkg;

  localparam int KEY_W = 10;
  localparam int LVL_W = 7;
  localparam int WT_W  = 7;
  localparam int SUM_W = 16;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [KEY_W-1:0] KEY_LIMIT_RESET = 10'd412;

  // operation codes
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_EMIT  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [LVL_W-1:0] lo;
    logic [LVL_W-1:0] hi;
    logic [SUM_W-1:0] sum;
  } rec_t;

  typedef struct packed {
    logic start_pass;
    logic clear_prev;
    logic take_prev;
    logic data_valid;
  } rank_ctl_t;

endpackage

// ===== hw/rtl/kmms_store.sv =====
module kmms_store #(
  parameter int DEPTH = 192,
  parameter int AW    = 8
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  kmms_pkg::rec_t     wr_data,
  input  logic [AW-1:0]      rd_addr,
  output kmms_pkg::rec_t     rd_data
);

  kmms_pkg::rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/kmms_rank.sv =====
module kmms_rank #(
  parameter int IW = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  kmms_pkg::rank_ctl_t ctl,
  input  kmms_pkg::rec_t      rd_rec,
  input  logic [IW-1:0]       rd_idx,
  output kmms_pkg::rec_t      best,
  output logic                have_best
);

  logic                       have_prev;
  logic [kmms_pkg::SUM_W-1:0] prev_sum;
  logic [IW-1:0]              prev_idx;
  logic [IW-1:0]              best_idx;
  logic                       qualify;
  logic                       better;

  // Order is weight descending, then index ascending. Each pass picks the
  // first record that follows the one emitted on the previous pass.
  always_comb begin
    qualify = !have_prev || (rd_rec.sum < prev_sum) ||
              ((rd_rec.sum == prev_sum) && (rd_idx > prev_idx));
    better  = !have_best || (rd_rec.sum > best.sum) ||
              ((rd_rec.sum == best.sum) && (rd_idx < best_idx));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      have_best <= 1'b0;
    end else begin
      if (ctl.clear_prev) begin
        have_prev <= 1'b0;
      end else if (ctl.take_prev) begin
        have_prev <= 1'b1;
        prev_sum  <= best.sum;
        prev_idx  <= best_idx;
      end
      if (ctl.start_pass) begin
        have_best <= 1'b0;
      end else if (ctl.data_valid && qualify && better) begin
        have_best <= 1'b1;
        best      <= rd_rec;
        best_idx  <= rd_idx;
      end
    end
  end

endmodule

// ===== hw/rtl/keyed_min_max_sum_aggregator_unit.sv =====
// Keyed min/max/sum aggregator over LISTS lists of up to ENTRIES records.
// Command channel: an item is taken on a clock edge with start high and
// busy low. operation selects add, emit or clear; list_index picks a list.
// An add searches the list in the record memory one entry per cycle, then
// merges into the matching record or appends a new one unless the list is
// full, holding busy until done (rejected key or bad list: busy stays low).
// A clear and an unused operation complete in the accept cycle.
// An emit runs one selection pass over the list per record it returns,
// a cost set by the single read port of the record memory. Results leave on
// result_valid, one cycle each, with last on the final one of the run.
// An empty list gives one result with entry_valid low and last high,
// in the cycle after the accept.
// Results cannot be held off; each is valid for exactly one cycle.
// cfg_write loads key_limit from cfg_data; write it only while idle.
// Reset clears every fill count and sets key_limit to 412; the record
// memory needs no clearing since only entries below a fill count are read.
module keyed_min_max_sum_aggregator_unit #(
  parameter int ENTRIES = 32,
  parameter int LISTS   = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [2:0]  list_index,
  input  logic [9:0]  record_key,
  input  logic [6:0]  level_low,
  input  logic [6:0]  level_high,
  input  logic [6:0]  weight,
  input  logic        cfg_write,
  input  logic [9:0]  cfg_data,
  output logic        result_valid,
  output logic        entry_valid,
  output logic [9:0]  out_key,
  output logic [6:0]  out_level_low,
  output logic [6:0]  out_level_high,
  output logic [15:0] out_weight,
  output logic        last
);

  localparam int DEPTH = LISTS * ENTRIES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = $clog2(ENTRIES);
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int LW    = (LISTS > 1) ? $clog2(LISTS) : 1;

  typedef enum logic [1:0] {
    IDLE,
    ADD_SCAN,
    EMIT_SCAN
  } state_t;

  state_t state;

  logic [9:0]    key_limit;
  logic [CW-1:0] fill [LISTS];

  logic [LW-1:0] lsel;
  logic [LW-1:0] lidx;
  logic [AW-1:0] base;
  logic [CW-1:0] n;
  logic [CW-1:0] cnt;
  logic [CW-1:0] k;
  logic          rd_pend;
  logic [IW-1:0] rd_idx;

  logic [kmms_pkg::KEY_W-1:0] key;
  logic [kmms_pkg::LVL_W-1:0] lo;
  logic [kmms_pkg::LVL_W-1:0] hi;
  logic [kmms_pkg::WT_W-1:0]  wt;

  logic accept;
  logic list_ok;
  logic key_ok;
  logic issue;
  logic hit;
  logic scan_done;
  logic run_last;
  logic [kmms_pkg::SUM_W:0] sum_wide;

  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;
  kmms_pkg::rec_t wr_data;
  kmms_pkg::rec_t rd_rec;
  kmms_pkg::rec_t merged;
  kmms_pkg::rec_t fresh;
  kmms_pkg::rec_t best;
  logic           have_best;
  kmms_pkg::rank_ctl_t rank_ctl;

  assign busy = (state != IDLE);

  always_comb begin
    accept    = start && !busy;
    lsel      = LW'(list_index);
    list_ok   = (32'(list_index) < LISTS);
    key_ok    = (record_key != '0) && (record_key < key_limit);
    hit       = (state == ADD_SCAN) && rd_pend && (rd_rec.key == key);
    issue     = ((state == ADD_SCAN) || (state == EMIT_SCAN)) && (cnt < n) && !hit;
    scan_done = !rd_pend && (cnt >= n);
    run_last  = (CW'(k + CW'(1)) == n);
    rd_addr   = base + AW'(cnt[IW-1:0]);

    sum_wide     = {1'b0, rd_rec.sum} + (kmms_pkg::SUM_W + 1)'(wt);
    merged.key   = rd_rec.key;
    merged.lo    = (lo < rd_rec.lo) ? lo : rd_rec.lo;
    merged.hi    = (hi > rd_rec.hi) ? hi : rd_rec.hi;
    merged.sum   = sum_wide[kmms_pkg::SUM_W] ? kmms_pkg::SUM_MAX
                                             : sum_wide[kmms_pkg::SUM_W-1:0];
    fresh.key    = key;
    fresh.lo     = lo;
    fresh.hi     = hi;
    fresh.sum    = kmms_pkg::SUM_W'(wt);

    wr_en   = hit || ((state == ADD_SCAN) && scan_done && (32'(n) < ENTRIES));
    wr_addr = hit ? (base + AW'(rd_idx)) : (base + AW'(n[IW-1:0]));
    wr_data = hit ? merged : fresh;

    rank_ctl.start_pass = (state == IDLE) || ((state == EMIT_SCAN) && scan_done);
    rank_ctl.clear_prev = (state == IDLE);
    rank_ctl.take_prev  = (state == EMIT_SCAN) && scan_done;
    rank_ctl.data_valid = (state == EMIT_SCAN) && rd_pend;
  end

  kmms_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_rec)
  );

  kmms_rank #(
    .IW (IW)
  ) u_rank (
    .clk       (clk),
    .rst       (rst),
    .ctl       (rank_ctl),
    .rd_rec    (rd_rec),
    .rd_idx    (rd_idx),
    .best      (best),
    .have_best (have_best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      key_limit    <= kmms_pkg::KEY_LIMIT_RESET;
      result_valid <= 1'b0;
      rd_pend      <= 1'b0;
      for (int i = 0; i < LISTS; i++) begin
        fill[i] <= '0;
      end
    end else begin
      result_valid <= 1'b0;
      rd_pend      <= issue;
      rd_idx       <= cnt[IW-1:0];
      if (issue) begin
        cnt <= cnt + CW'(1);
      end
      if (cfg_write) begin
        key_limit <= cfg_data;
      end
      unique case (state)
        IDLE: begin
          if (accept && list_ok) begin
            lidx <= lsel;
            base <= AW'(32'(lsel) * ENTRIES);
            n    <= fill[lsel];
            cnt  <= '0;
            k    <= '0;
            key  <= record_key;
            lo   <= level_low;
            hi   <= level_high;
            wt   <= weight;
            unique case (operation)
              kmms_pkg::OP_ADD: begin
                if (key_ok) begin
                  state <= ADD_SCAN;
                end
              end
              kmms_pkg::OP_EMIT: begin
                if (fill[lsel] == '0) begin
                  // empty list: a lone marker result
                  result_valid   <= 1'b1;
                  entry_valid    <= 1'b0;
                  last           <= 1'b1;
                  out_key        <= '0;
                  out_level_low  <= '0;
                  out_level_high <= '0;
                  out_weight     <= '0;
                end else begin
                  state <= EMIT_SCAN;
                end
              end
              kmms_pkg::OP_CLEAR: begin
                fill[lsel] <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ADD_SCAN: begin
          if (hit) begin
            state <= IDLE;
          end else if (scan_done) begin
            // no match: append unless full
            state <= IDLE;
            if (32'(n) < ENTRIES) begin
              fill[lidx] <= CW'(n + CW'(1));
            end
          end
        end
        EMIT_SCAN: begin
          if (scan_done) begin
            result_valid   <= 1'b1;
            entry_valid    <= 1'b1;
            last           <= run_last;
            out_key        <= best.key;
            out_level_low  <= best.lo;
            out_level_high <= best.hi;
            out_weight     <= best.sum;
            k              <= CW'(k + CW'(1));
            if (run_last) begin
              state <= IDLE;
            end else begin
              cnt <= '0;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (32'(n) <= ENTRIES))
    else $error("fill count above list capacity");

  a_pass_finds: assert property (@(posedge clk) disable iff (rst)
    ((state == EMIT_SCAN) && scan_done) |-> have_best)
    else $error("selection pass ended without a record");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ADD_SCAN))
    else $error("record write outside an add");

  a_no_early_entry: assert property (@(posedge clk) disable iff (rst)
    accept |=> !(result_valid && entry_valid))
    else $error("record emitted right after accept");
`endif

endmodule
